/* hdl/alpe_pkg.sv */
// Shared types and codes for the array list partition engine.
// Used by alpe_ctrl, alpe_datapath and array_list_partition_engine_core.
`default_nettype none
package alpe_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT    = 2'd0,
		CMD_DELETE    = 2'd1,
		CMD_READ      = 2'd2,
		CMD_PARTITION = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// Source of the data written into the element memory.
	typedef enum logic [1:0] {
		WSEL_RD   = 2'd0,
		WSEL_VAL  = 2'd1,
		WSEL_ZERO = 2'd2
	} wsel_t;

	localparam int unsigned ElemW = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  rd_en;
		logic  wr_en;
		logic  wr_alt;
		wsel_t wr_sel;
		logic  load_val;
		logic  clr_res;
		logic  cap_res;
		logic  flip;
	} dp_cmd_t;

	// Classification of the registered read data.
	typedef struct packed {
		logic pos;
		logic zero;
		logic neg;
	} dp_flags_t;

endpackage
`default_nettype wire

/* hdl/array_list_partition_engine_core.sv */
// Top level of the array list partition engine.
// Depends on alpe_pkg, alpe_ctrl and alpe_datapath.
//
// The engine keeps an ordered list of up to DEPTH signed 32-bit elements and
// runs one command per item: insert at a 1-based position, delete at a
// position (returning the removed element), read at a position, or a stable
// three-way partition that moves positives first, zeros next and negatives
// last. An item is taken on a clock edge where start is high and busy is low.
// Each item produces exactly one result, shown for a single cycle while done
// is high; the receiver cannot hold it off and must take it in that cycle.
// A bad position answers with status one and a full list with status two,
// both in the cycle after the item, leaving the list untouched. Timing follows
// the single read and single write port of the element memory. An insert
// reads the elements from the end down to position p and writes each one a
// place higher, then writes the new value at p; a delete reads from p to the
// end, keeps the first as its result and writes the rest a place lower; a
// partition scans for positives, writes the zeros, then scans for negatives.
// The result strobe comes in the first cycle with busy low again.
// The partition writes its output into a second bank and then swaps banks,
// so no copy-back pass is needed.
// The memory needs no clearing after reset; only written entries are read.
`default_nettype none
module array_list_partition_engine_core #(
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          cmd,
	input  wire logic [7:0]          position,
	input  wire logic signed [31:0]  value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [31:0]       result_value,
	output logic [7:0]               list_length
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	alpe_pkg::dp_cmd_t   dcmd;
	alpe_pkg::dp_flags_t flags;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;

	// Sequencer: decodes the item, checks positions and steps the shifts.
	alpe_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.position   (position),
		.flags      (flags),
		.dcmd       (dcmd),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.busy       (busy),
		.done       (done),
		.status     (status),
		.list_length(list_length)
	);

	// Element memory and the registers for the inserted and returned values.
	alpe_datapath #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dcmd        (dcmd),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.value       (value),
		.flags       (flags),
		.result_value(result_value)
	);

endmodule
`default_nettype wire

/* hdl/alpe_datapath.sv */
// Datapath: double-banked element memory, value and result registers.
// Depends on alpe_pkg; driven by alpe_ctrl.
`default_nettype none
module alpe_datapath #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire alpe_pkg::dp_cmd_t                 dcmd,
	input  wire logic [AW-1:0]                     rd_addr,
	input  wire logic [AW-1:0]                     wr_addr,
	input  wire logic signed [alpe_pkg::ElemW-1:0] value,
	output alpe_pkg::dp_flags_t                    flags,
	output logic signed [alpe_pkg::ElemW-1:0]      result_value
);

	// Each bank spans the full address range so {bank, addr} always lands inside.
	localparam int unsigned Entries = 2 ** (AW + 1);

	logic [alpe_pkg::ElemW-1:0] mem [Entries];
	logic [alpe_pkg::ElemW-1:0] rdata_q;
	logic [alpe_pkg::ElemW-1:0] val_q;
	logic [alpe_pkg::ElemW-1:0] res_q;
	logic [alpe_pkg::ElemW-1:0] wdata;
	logic                       bank_q;

	always_comb begin
		case (dcmd.wr_sel)
			alpe_pkg::WSEL_RD:  wdata = rdata_q;
			alpe_pkg::WSEL_VAL: wdata = val_q;
			default:            wdata = '0;
		endcase
	end

	// Partition writes go to the other bank, which becomes active at the end.
	always_ff @(posedge clk) begin
		if (dcmd.wr_en) begin
			mem[{bank_q ^ dcmd.wr_alt, wr_addr}] <= wdata;
		end
		if (dcmd.rd_en) begin
			rdata_q <= mem[{bank_q, rd_addr}];
		end
		if (dcmd.load_val) begin
			val_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			res_q  <= '0;
		end else begin
			if (dcmd.flip) begin
				bank_q <= ~bank_q;
			end
			if (dcmd.clr_res) begin
				res_q <= '0;
			end else if (dcmd.cap_res) begin
				res_q <= rdata_q;
			end
		end
	end

	assign flags.zero   = (rdata_q == '0);
	assign flags.neg    = rdata_q[alpe_pkg::ElemW-1];
	assign flags.pos    = !rdata_q[alpe_pkg::ElemW-1] && (rdata_q != '0);
	assign result_value = res_q;

endmodule
`default_nettype wire

/* hdl/alpe_ctrl.sv */
// Controller: command decode, shift and partition sequencing, result registers.
// Depends on alpe_pkg; commands alpe_datapath.
`default_nettype none
module alpe_ctrl #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = $clog2(DEPTH),
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [1:0]          cmd,
	input  wire logic [7:0]          position,
	input  wire alpe_pkg::dp_flags_t flags,
	output alpe_pkg::dp_cmd_t        dcmd,
	output logic [AW-1:0]            rd_addr,
	output logic [AW-1:0]            wr_addr,
	output logic                     busy,
	output logic                     done,
	output logic [1:0]               status,
	output logic [7:0]               list_length
);

	localparam int unsigned XW = ((CW > 8) ? CW : 8) + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_INS, S_DN, S_P_POS, S_P_ZERO, S_P_NEG
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rem_q;
	logic [CW-1:0]       zc_q;
	logic [AW-1:0]       idx_q;
	logic [AW-1:0]       paddr_q;
	logic [AW-1:0]       ppos_q;
	logic [AW-1:0]       w_q;
	logic                pend_q;
	logic                first_q;
	logic                del_q;
	logic                done_q;
	alpe_pkg::status_t   status_q;
	logic [7:0]          len_q;

	logic [XW-1:0] cnt_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_inc;
	logic [XW-1:0] cnt_dec;
	logic          drained;

	assign cnt_x   = XW'(count_q);
	assign pos_x   = XW'(position);
	assign cnt_inc = cnt_x + XW'(1);
	assign cnt_dec = cnt_x - XW'(1);
	assign drained = (rem_q == '0) && !pend_q;

	always_comb begin
		dcmd    = '0;
		rd_addr = idx_q;
		wr_addr = '0;
		case (state_q)
			S_IDLE: begin
				dcmd.load_val = start;
				dcmd.clr_res  = start;
			end
			S_INS: begin
				dcmd.rd_en = (rem_q != '0);
				if (pend_q) begin
					dcmd.wr_en  = 1'b1;
					dcmd.wr_sel = alpe_pkg::WSEL_RD;
					wr_addr     = paddr_q + AW'(1);
				end else if (rem_q == '0) begin
					dcmd.wr_en  = 1'b1;
					dcmd.wr_sel = alpe_pkg::WSEL_VAL;
					wr_addr     = ppos_q;
				end
			end
			S_DN: begin
				dcmd.rd_en = (rem_q != '0);
				if (pend_q && first_q) begin
					dcmd.cap_res = 1'b1;
				end else if (pend_q) begin
					dcmd.wr_en  = 1'b1;
					dcmd.wr_sel = alpe_pkg::WSEL_RD;
					wr_addr     = paddr_q - AW'(1);
				end
			end
			S_P_POS: begin
				dcmd.rd_en  = (rem_q != '0);
				dcmd.wr_en  = pend_q && flags.pos;
				dcmd.wr_alt = 1'b1;
				dcmd.wr_sel = alpe_pkg::WSEL_RD;
				wr_addr     = w_q;
			end
			S_P_ZERO: begin
				dcmd.wr_en  = (zc_q != '0);
				dcmd.wr_alt = 1'b1;
				dcmd.wr_sel = alpe_pkg::WSEL_ZERO;
				wr_addr     = w_q;
			end
			S_P_NEG: begin
				dcmd.rd_en  = (rem_q != '0);
				dcmd.wr_en  = pend_q && flags.neg;
				dcmd.wr_alt = 1'b1;
				dcmd.wr_sel = alpe_pkg::WSEL_RD;
				wr_addr     = w_q;
				dcmd.flip   = drained;
			end
			default: begin
				dcmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rem_q    <= '0;
			zc_q     <= '0;
			idx_q    <= '0;
			paddr_q  <= '0;
			ppos_q   <= '0;
			w_q      <= '0;
			pend_q   <= 1'b0;
			first_q  <= 1'b0;
			del_q    <= 1'b0;
			done_q   <= 1'b0;
			status_q <= alpe_pkg::ST_OK;
			len_q    <= '0;
		end else begin
			done_q  <= 1'b0;
			pend_q  <= dcmd.rd_en;
			paddr_q <= idx_q;
			if (dcmd.rd_en) begin
				rem_q <= rem_q - CW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (cmd)
							alpe_pkg::CMD_INSERT: begin
								if (pos_x == '0 || pos_x > cnt_inc) begin
									done_q   <= 1'b1;
									status_q <= alpe_pkg::ST_BADPOS;
									len_q    <= cnt_x[7:0];
								end else if (cnt_x == XW'(DEPTH)) begin
									done_q   <= 1'b1;
									status_q <= alpe_pkg::ST_FULL;
									len_q    <= cnt_x[7:0];
								end else begin
									state_q <= S_INS;
									rem_q   <= CW'(cnt_inc - pos_x);
									idx_q   <= AW'(cnt_dec);
									ppos_q  <= AW'(pos_x - XW'(1));
								end
							end
							alpe_pkg::CMD_DELETE, alpe_pkg::CMD_READ: begin
								if (pos_x == '0 || pos_x > cnt_x) begin
									done_q   <= 1'b1;
									status_q <= alpe_pkg::ST_BADPOS;
									len_q    <= cnt_x[7:0];
								end else begin
									state_q <= S_DN;
									del_q   <= (cmd == alpe_pkg::CMD_DELETE);
									rem_q   <= (cmd == alpe_pkg::CMD_DELETE) ?
										CW'(cnt_inc - pos_x) : CW'(1);
									idx_q   <= AW'(pos_x - XW'(1));
									first_q <= 1'b1;
								end
							end
							default: begin
								state_q <= S_P_POS;
								rem_q   <= count_q;
								idx_q   <= '0;
								w_q     <= '0;
								zc_q    <= '0;
							end
						endcase
					end
				end
				S_INS: begin
					if (dcmd.rd_en) begin
						idx_q <= idx_q - AW'(1);
					end
					if (drained) begin
						count_q  <= CW'(cnt_inc);
						done_q   <= 1'b1;
						status_q <= alpe_pkg::ST_OK;
						len_q    <= cnt_inc[7:0];
						state_q  <= S_IDLE;
					end
				end
				S_DN: begin
					if (dcmd.rd_en) begin
						idx_q <= idx_q + AW'(1);
					end
					if (pend_q) begin
						first_q <= 1'b0;
					end
					if (drained) begin
						done_q   <= 1'b1;
						status_q <= alpe_pkg::ST_OK;
						state_q  <= S_IDLE;
						if (del_q) begin
							count_q <= CW'(cnt_dec);
							len_q   <= cnt_dec[7:0];
						end else begin
							len_q   <= cnt_x[7:0];
						end
					end
				end
				S_P_POS: begin
					if (dcmd.rd_en) begin
						idx_q <= idx_q + AW'(1);
					end
					if (dcmd.wr_en) begin
						w_q <= w_q + AW'(1);
					end
					if (pend_q && flags.zero) begin
						zc_q <= zc_q + CW'(1);
					end
					if (drained) begin
						state_q <= S_P_ZERO;
					end
				end
				S_P_ZERO: begin
					if (zc_q != '0) begin
						w_q  <= w_q + AW'(1);
						zc_q <= zc_q - CW'(1);
					end else begin
						state_q <= S_P_NEG;
						rem_q   <= count_q;
						idx_q   <= '0;
					end
				end
				S_P_NEG: begin
					if (dcmd.rd_en) begin
						idx_q <= idx_q + AW'(1);
					end
					if (dcmd.wr_en) begin
						w_q <= w_q + AW'(1);
					end
					if (drained) begin
						done_q   <= 1'b1;
						status_q <= alpe_pkg::ST_OK;
						len_q    <= cnt_x[7:0];
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign list_length = len_q;

	// A result is only ever delivered when the sequencer has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while sequencer busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count beyond depth");

	// No read may be left outstanding when the sequencer goes idle.
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q != S_IDLE)
		else $error("read in flight while idle");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == alpe_pkg::ST_FULL) |-> count_q == CW'(DEPTH))
		else $error("full status with room left");

	// Every accepted item either answers at once or starts a sequence.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done_q))
		else $error("accepted item dropped");

endmodule
`default_nettype wire
